// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants and types for the bounded double-ended queue: command
// and status codes, and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE_POS  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_POS   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Controller to datapath: one operation flag at most, already checked.
  typedef struct packed {
    logic                step;
    logic                push_front;
    logic                push_back;
    logic                pop_front;
    logic                pop_back;
    logic                write_pos;
    logic                read_pos;
    logic [STATUS_W-1:0] status;
  } dp_cmd_t;

  // Datapath to controller: occupancy checks for the item at the input.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_ok;
  } dp_stat_t;

endpackage

// ===== rtl/bdq_datapath.sv =====
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring storage with front pointer and count. Computes ring addresses,
// performs at most one write or one registered read per item, and holds the
// result payload.
// ----------------------------------------------------------------------------
module bdq_datapath #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bdq_pkg::dp_cmd_t             cmd,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic [AW-1:0]                position,
  output bdq_pkg::dp_stat_t            stat,
  output logic signed [DATA_WIDTH-1:0] data,
  output logic [CW-1:0]                occupancy,
  output logic [bdq_pkg::STATUS_W-1:0] status
);

  localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  data_sel;
  logic [AW-1:0]         front;
  logic [CW-1:0]         count;
  logic [AW-1:0]         front_next;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         count_dec;
  logic [AW-1:0]         front_dec;
  logic [AW-1:0]         front_inc;
  logic [AW-1:0]         back_idx;
  logic [AW-1:0]         last_idx;
  logic [AW-1:0]         pos_idx;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic                  rd_en;

  // Add an offset to a ring index and wrap once.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_V) begin
      s = s - DEPTH_V;
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    count_dec = count - CW'(1);
    front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
    front_inc = ring_add(front, AW'(1));
    back_idx  = ring_add(front, count[AW-1:0]);
    last_idx  = ring_add(front, count_dec[AW-1:0]);
    pos_idx   = ring_add(front, position);

    stat.full   = (count == CW'(DEPTH));
    stat.empty  = (count == '0);
    stat.pos_ok = (CW'(position) < count);

    wr_en   = cmd.push_front | cmd.push_back | cmd.write_pos;
    rd_en   = cmd.pop_front | cmd.pop_back | cmd.read_pos;
    wr_addr = cmd.push_front ? front_dec : (cmd.push_back ? back_idx : pos_idx);
    rd_addr = cmd.pop_front ? front : (cmd.pop_back ? last_idx : pos_idx);

    front_next = front;
    count_next = count;
    if (cmd.push_front) begin
      front_next = front_dec;
    end
    if (cmd.pop_front) begin
      front_next = front_inc;
    end
    if (cmd.push_front || cmd.push_back) begin
      count_next = count + CW'(1);
    end
    if (cmd.pop_front || cmd.pop_back) begin
      count_next = count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      data_sel <= 1'b0;
      status   <= bdq_pkg::ST_OK;
    end else if (cmd.step) begin
      front    <= front_next;
      count    <= count_next;
      data_sel <= rd_en;
      status   <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && wr_en) begin
      mem[wr_addr] <= value;
    end
    if (cmd.step && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Count after the step is the occupancy of the held result.
  assign occupancy = count;
  assign data      = data_sel ? rd_data : '0;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count above depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    cmd.step && (cmd.push_front || cmd.push_back) |=> count == $past(count) + CW'(1))
    else $error("push did not grow count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.step && (cmd.pop_front || cmd.pop_back) |=> count == $past(count) - CW'(1))
    else $error("pop did not shrink count");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    cmd.step && cmd.status != bdq_pkg::ST_OK |=> !data_sel && $stable(count))
    else $error("failed item changed state or returned data");

endmodule

// ===== rtl/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Handshake controller and command decoder. Checks each item against the
// datapath status, picks the operation and status code, and tracks the
// output register.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bdq_pkg::CMD_W-1:0] cmd,
  input  bdq_pkg::dp_stat_t         stat,
  output bdq_pkg::dp_cmd_t          dp_cmd,
  output logic                      out_valid,
  input  logic                      out_ready
);

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_t;

  state_t state;
  logic   step;

  // Take a new item when the output register is empty or drains this cycle.
  assign in_ready = (state == S_IDLE) || out_ready;
  assign step     = in_valid && in_ready;

  always_comb begin
    dp_cmd        = '0;
    dp_cmd.step   = step;
    dp_cmd.status = bdq_pkg::ST_OK;
    case (cmd)
      bdq_pkg::CMD_PUSH_FRONT: begin
        if (stat.full) dp_cmd.status = bdq_pkg::ST_FULL;
        else dp_cmd.push_front = 1'b1;
      end
      bdq_pkg::CMD_PUSH_BACK: begin
        if (stat.full) dp_cmd.status = bdq_pkg::ST_FULL;
        else dp_cmd.push_back = 1'b1;
      end
      bdq_pkg::CMD_POP_FRONT: begin
        if (stat.empty) dp_cmd.status = bdq_pkg::ST_EMPTY;
        else dp_cmd.pop_front = 1'b1;
      end
      bdq_pkg::CMD_POP_BACK: begin
        if (stat.empty) dp_cmd.status = bdq_pkg::ST_EMPTY;
        else dp_cmd.pop_back = 1'b1;
      end
      bdq_pkg::CMD_WRITE_POS: begin
        if (!stat.pos_ok) dp_cmd.status = bdq_pkg::ST_RANGE;
        else dp_cmd.write_pos = 1'b1;
      end
      bdq_pkg::CMD_READ_POS: begin
        if (!stat.pos_ok) dp_cmd.status = bdq_pkg::ST_RANGE;
        else dp_cmd.read_pos = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (step) state <= S_HOLD;
        end
        S_HOLD: begin
          if (out_ready && !step) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = (state == S_HOLD);

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({dp_cmd.push_front, dp_cmd.push_back, dp_cmd.pop_front,
              dp_cmd.pop_back, dp_cmd.write_pos, dp_cmd.read_pos}))
    else $error("more than one operation selected");

  a_fail_no_op: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.status != bdq_pkg::ST_OK |-> !(dp_cmd.push_front || dp_cmd.push_back ||
      dp_cmd.pop_front || dp_cmd.pop_back || dp_cmd.write_pos || dp_cmd.read_pos))
    else $error("operation issued on failed check");

  a_step_holds: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted item produced no result");

endmodule

// ===== rtl/bounded_deque_indexed_top.sv =====
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while out_ready is high; the result comes
// from a registered read of the ring memory.
// A new item is taken in the cycle the held result is taken.
// Reset (rst, synchronous): queue empty, front pointer zero, no result held.
// Ring entries are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
// bounded_deque_indexed_top
// Bounded double-ended queue of signed integers with push and pop at both
// ends and indexed read and overwrite.
// ----------------------------------------------------------------------------
module bounded_deque_indexed_top #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bdq_pkg::CMD_W-1:0]    cmd,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic [AW-1:0]                position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] data,
  output logic [CW-1:0]                occupancy,
  output logic [bdq_pkg::STATUS_W-1:0] status
);

  bdq_pkg::dp_cmd_t  dp_cmd;
  bdq_pkg::dp_stat_t dp_stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .stat      (dp_stat),
    .dp_cmd    (dp_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  bdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .value     (value),
    .position  (position),
    .stat      (dp_stat),
    .data      (data),
    .occupancy (occupancy),
    .status    (status)
  );

endmodule

// ===== dv/bounded_deque_indexed_checker.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_indexed_checker
// Watches both channels of the deque. Every accepted command is run through
// a private copy of the ring, front index and fill level. The result that
// copy produces is queued and compared, whole item, against the next result
// taken from the block.
// ----------------------------------------------------------------------------
module bounded_deque_indexed_checker
  import bdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [CMD_W-1:0]             cmd,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic [AW-1:0]                position,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [DATA_WIDTH-1:0] data,
  input  logic [CW-1:0]                occupancy,
  input  logic [STATUS_W-1:0]          status,
  output int                           fail_count,
  output int                           pending,
  output int                           fill_now,
  output int                           results_seen,
  output int                           full_hits,
  output int                           empty_hits,
  output int                           range_hits
);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] data;
    logic [CW-1:0]                occupancy;
    logic [STATUS_W-1:0]          status;
  } deque_result_t;

  logic signed [DATA_WIDTH-1:0] ring_mem [DEPTH];
  logic [AW-1:0]                head_idx = '0;
  int                           held = 0;
  deque_result_t                awaited_results [$];
  int                           errors = 0;
  int                           taken = 0;
  int                           n_full = 0;
  int                           n_empty = 0;
  int                           n_range = 0;

  function automatic logic [AW-1:0] ring_at(int offset);
    return AW'((int'(head_idx) + offset) % DEPTH);
  endfunction

  // Advance the private queue by one command and return the result it gives.
  function automatic deque_result_t deque_apply(logic [CMD_W-1:0] c,
                                                logic signed [DATA_WIDTH-1:0] v,
                                                logic [AW-1:0] p);
    deque_result_t r;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_idx = ring_at(DEPTH - 1);
          ring_mem[head_idx] = v;
          held++;
        end
      end
      CMD_PUSH_BACK: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[ring_at(held)] = v;
          held++;
        end
      end
      CMD_POP_FRONT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = ring_mem[head_idx];
          head_idx = ring_at(1);
          held--;
        end
      end
      CMD_POP_BACK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = ring_mem[ring_at(held - 1)];
          held--;
        end
      end
      CMD_WRITE_POS, CMD_READ_POS: begin
        if (int'(p) >= held) begin
          r.status = ST_RANGE;
        end else if (c == CMD_WRITE_POS) begin
          ring_mem[ring_at(int'(p))] = v;
        end else begin
          r.data = ring_mem[ring_at(int'(p))];
        end
      end
      default: begin
        // spare codes leave the queue alone
      end
    endcase
    r.occupancy = CW'(held);
    return r;
  endfunction

  task automatic report_failure(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst) begin
      head_idx = '0;
      held = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.data = data;
        got.occupancy = occupancy;
        got.status = status;
        taken++;
        if (awaited_results.size() == 0) begin
          report_failure($sformatf("result %0d: nothing awaited, got data %0d occ %0d st %0d",
                                   taken, got.data, got.occupancy, got.status));
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            report_failure($sformatf(
              "result %0d: want data %0d occ %0d st %0d, got data %0d occ %0d st %0d",
              taken, want.data, want.occupancy, want.status,
              got.data, got.occupancy, got.status));
          end
        end
      end
      if (in_valid && in_ready) begin
        want = deque_apply(cmd, value, position);
        awaited_results.push_back(want);
        case (want.status)
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          ST_RANGE: n_range++;
          default:  ;
        endcase
      end
    end
    fail_count   <= errors;
    pending      <= awaited_results.size();
    fill_now     <= held;
    results_seen <= taken;
    full_hits    <= n_full;
    empty_hits   <= n_empty;
    range_hits   <= n_range;
  end

endmodule

// ===== dv/bounded_deque_indexed_top_test.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_indexed_top_test
// Drives the deque with a directed opener covering empty, full, edge values
// and bad positions, then with random command mixes that lean toward
// filling, draining or neither, under several idle and stall mixes. A checker
// alongside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bounded_deque_indexed_top_test;
  import bdq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
  localparam int AW          = $clog2(DEPTH);
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 170;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         out_ready = 1'b0;
  logic [CMD_W-1:0]             cmd = CMD_PUSH_FRONT;
  logic signed [DATA_WIDTH-1:0] value = '0;
  logic [AW-1:0]                position = '0;
  wire                          in_ready;
  wire                          out_valid;
  wire signed [DATA_WIDTH-1:0]  data;
  wire [CW-1:0]                 occupancy;
  wire [STATUS_W-1:0]           status;

  int fail_count;
  int pending;
  int fill_now;
  int results_seen;
  int full_hits;
  int empty_hits;
  int range_hits;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int commands_sent = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int k;

  bounded_deque_indexed_top #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .value(value), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .data(data), .occupancy(occupancy), .status(status)
  );

  bounded_deque_indexed_checker #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) deque_watch (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .value(value), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .data(data), .occupancy(occupancy), .status(status),
    .fail_count(fail_count), .pending(pending), .fill_now(fill_now),
    .results_seen(results_seen), .full_hits(full_hits),
    .empty_hits(empty_hits), .range_hits(range_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Receiver: random stalls, plus one long hold when asked.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // End the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("bounded_deque_indexed_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item and hold it until taken; valid stays high on return.
  task automatic send(logic [CMD_W-1:0] c, logic signed [DATA_WIDTH-1:0] v,
                      logic [AW-1:0] p);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    value    <= v;
    position <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    commands_sent++;
  endtask

  // Drop valid and wait until every awaited result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(19))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  // lean 2 favors pushes, 0 favors pops, 1 is even
  function automatic logic [CMD_W-1:0] pick_cmd(int lean);
    int r;
    int push_cut;
    int pop_cut;
    r = $urandom_range(99);
    push_cut = (lean == 2) ? 60 : (lean == 1) ? 36 : 16;
    pop_cut  = push_cut + ((lean == 2) ? 18 : (lean == 1) ? 32 : 60);
    if (r < push_cut) begin
      return (r < push_cut / 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end else if (r < pop_cut) begin
      return (r < (push_cut + pop_cut) / 2) ? CMD_POP_FRONT : CMD_POP_BACK;
    end else if (r < 97) begin
      return (r < (pop_cut + 97) / 2) ? CMD_WRITE_POS : CMD_READ_POS;
    end else begin
      return r[0] ? CMD_SPARE_7 : CMD_SPARE_6;
    end
  endfunction

  // Mostly land inside the queue; the rest span the whole field.
  function automatic logic [AW-1:0] pick_pos();
    if (fill_now > 0 && $urandom_range(3) != 0) begin
      return AW'($urandom_range(fill_now - 1));
    end
    return AW'($urandom_range(DEPTH - 1));
  endfunction

  task automatic run_random(int n);
    int lean;
    lean = 1;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) lean = $urandom_range(2);
      send(pick_cmd(lean), pick_value(), pick_pos());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty queue: pops and positions all rejected, spare codes ignored
    send(CMD_POP_FRONT, VAL_MAX, '0);
    send(CMD_POP_BACK, VAL_MIN, '1);
    send(CMD_READ_POS, '0, '0);
    send(CMD_WRITE_POS, VAL_MAX, '1);
    send(CMD_SPARE_6, VAL_MIN, '1);
    send(CMD_SPARE_7, '1, '0);
    // fill to the brim from both ends, then push into a full queue
    send(CMD_PUSH_FRONT, VAL_MIN, '0);
    send(CMD_PUSH_BACK, VAL_MAX, '1);
    for (k = 2; k < DEPTH; k++) begin
      send((k % 2 != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value(), '0);
    end
    send(CMD_PUSH_FRONT, 1, '0);
    send(CMD_PUSH_BACK, 2, '0);
    send(CMD_READ_POS, '0, '1);
    send(CMD_WRITE_POS, '1, '1);
    send(CMD_READ_POS, '0, '1);
    send(CMD_READ_POS, '0, '0);
    send(CMD_POP_BACK, '0, '0);
    send(CMD_POP_FRONT, '0, '0);
    // count is now one short of the last position
    send(CMD_READ_POS, '0, AW'(DEPTH - 2));
    send(CMD_WRITE_POS, '0, AW'(DEPTH - 2));
    drain();

    send_idle_pct = 0;
    stall_pct = 0;
    run_random(PHASE_ITEMS);
    drain();

    // long receiver hold while the sender keeps sending, mostly pushes
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) begin
      send(pick_cmd(2), pick_value(), pick_pos());
    end
    drain();

    send_idle_pct = 88;
    stall_pct = 0;
    run_random(PHASE_ITEMS);
    drain();

    send_idle_pct = 0;
    stall_pct = 88;
    run_random(PHASE_ITEMS);
    drain();

    send_idle_pct = 12;
    stall_pct = 12;
    run_random(PHASE_ITEMS);
    drain();

    repeat (4) @(posedge clk);
    $display("Ran %0d deque commands across four idle/stall mixes, %0d results checked.",
             commands_sent, results_seen);
    $display("Full on %0d pushes, empty on %0d pops, bad position on %0d accesses.",
             full_hits, empty_hits, range_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("bounded_deque_indexed_top: match");
    end else begin
      $display("bounded_deque_indexed_top: mismatch");
    end
    $finish;
  end

endmodule
